// File: sv/assert_macros.svh
// Concurrent assertion helpers used by the checker file ctt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ctt_pkg.sv
`timescale 1ns / 1ps

package ctt_pkg;

  localparam int USER_SLOTS  = 16;
  localparam int TOKEN_SLOTS = 64;

  localparam int ID_W          = 32;
  localparam int CAPS_W        = 32;
  localparam int MODE_W        = 3;
  localparam int STATUS_W      = 3;
  localparam int LIVE_TOKENS_W = 7;
  localparam int LIVE_USERS_W  = 5;

  localparam int USER_AW   = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int TOKEN_AW  = (TOKEN_SLOTS > 1) ? $clog2(TOKEN_SLOTS) : 1;
  localparam int MAX_SLOTS = (USER_SLOTS > TOKEN_SLOTS) ? USER_SLOTS : TOKEN_SLOTS;
  localparam int SCAN_W    = $clog2(MAX_SLOTS + 1);
  localparam int TCNT_W    = $clog2(TOKEN_SLOTS + 1);
  localparam int UCNT_W    = $clog2(USER_SLOTS + 1);

  localparam logic [SCAN_W-1:0] USER_LIMIT  = SCAN_W'(USER_SLOTS);
  localparam logic [SCAN_W-1:0] TOKEN_LIMIT = SCAN_W'(TOKEN_SLOTS);
  localparam logic [SCAN_W-1:0] USER_LAST   = SCAN_W'(USER_SLOTS - 1);
  localparam logic [SCAN_W-1:0] TOKEN_LAST  = SCAN_W'(TOKEN_SLOTS - 1);

  localparam logic [MODE_W-1:0] MODE_LOGIN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VERIFY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REVOKE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STATUS = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOKENS_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_USER_EXISTS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_USERS_FULL  = 3'd4;

  localparam logic [ID_W-1:0]       ROOT_IDENT     = 32'd0;
  localparam logic [CAPS_W-1:0]     ROOT_CAPS      = 32'h0000_00FF;
  localparam logic [ID_W-1:0]       ADMIN_IDENT    = 32'd1;
  localparam logic [CAPS_W-1:0]     ADMIN_CAPS     = 32'h0000_003F;
  localparam logic [ID_W-1:0]       NEXT_IDENT_RST = 32'd1;
  localparam logic [UCNT_W-1:0]     USER_COUNT_RST = UCNT_W'(2);
  localparam logic [USER_SLOTS-1:0] USER_VALID_RST = USER_SLOTS'(2'b11);

  typedef struct packed {
    logic               en;
    logic [USER_AW-1:0] addr;
    logic [ID_W-1:0]    ident;
    logic [CAPS_W-1:0]  caps;
  } user_wr_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   ident;
    logic [CAPS_W-1:0] caps;
  } user_rd_t;

  typedef struct packed {
    logic                set;
    logic                clr;
    logic [TOKEN_AW-1:0] addr;
    logic [ID_W-1:0]     ident;
    logic [ID_W-1:0]     owner;
    logic [CAPS_W-1:0]   caps;
  } token_wr_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   ident;
    logic [ID_W-1:0]   owner;
    logic [CAPS_W-1:0] caps;
  } token_rd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ID_W-1:0]          issued;
    logic [ID_W-1:0]          owner;
    logic [CAPS_W-1:0]        caps;
    logic [LIVE_TOKENS_W-1:0] live_tokens;
    logic [LIVE_USERS_W-1:0]  live_users;
  } result_t;

endpackage

// File: sv/ctt_user_store.sv
`timescale 1ns / 1ps

module ctt_user_store import ctt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [USER_AW-1:0] rd_addr_i,
  input  user_wr_t           wr_i,
  output user_rd_t           rd_o
);

  logic [ID_W-1:0]   ident_mem [USER_SLOTS];
  logic [CAPS_W-1:0] caps_mem  [USER_SLOTS];

  logic [USER_SLOTS-1:0] valid_q;
  logic [USER_SLOTS-1:0] written_q;
  logic                  rd_valid_q;
  logic                  rd_written_q;
  logic [USER_AW-1:0]    rd_addr_q;
  logic [ID_W-1:0]       rd_ident_q;
  logic [CAPS_W-1:0]     rd_caps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= USER_VALID_RST;
      written_q    <= '0;
      rd_valid_q   <= 1'b0;
      rd_written_q <= 1'b0;
    end else begin
      rd_valid_q   <= valid_q[rd_addr_i];
      rd_written_q <= written_q[rd_addr_i];
      if (wr_i.en) begin
        valid_q[wr_i.addr]   <= 1'b1;
        written_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_i;
    rd_ident_q <= ident_mem[rd_addr_i];
    rd_caps_q  <= caps_mem[rd_addr_i];
    if (wr_i.en) begin
      ident_mem[wr_i.addr] <= wr_i.ident;
      caps_mem[wr_i.addr]  <= wr_i.caps;
    end
  end

  // Entries never written since reset read as the built-in admin user at slot 1 and as the root user elsewhere.
  always_comb begin
    rd_o.valid = rd_valid_q;
    if (rd_written_q) begin
      rd_o.ident = rd_ident_q;
      rd_o.caps  = rd_caps_q;
    end else if (rd_addr_q == USER_AW'(1)) begin
      rd_o.ident = ADMIN_IDENT;
      rd_o.caps  = ADMIN_CAPS;
    end else begin
      rd_o.ident = ROOT_IDENT;
      rd_o.caps  = ROOT_CAPS;
    end
  end

endmodule

// File: sv/ctt_token_store.sv
`timescale 1ns / 1ps

module ctt_token_store import ctt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [TOKEN_AW-1:0] rd_addr_i,
  input  token_wr_t           wr_i,
  output token_rd_t           rd_o
);

  logic [ID_W-1:0]   ident_mem [TOKEN_SLOTS];
  logic [ID_W-1:0]   owner_mem [TOKEN_SLOTS];
  logic [CAPS_W-1:0] caps_mem  [TOKEN_SLOTS];

  logic [TOKEN_SLOTS-1:0] valid_q;
  logic                   rd_valid_q;
  logic [ID_W-1:0]        rd_ident_q;
  logic [ID_W-1:0]        rd_owner_q;
  logic [CAPS_W-1:0]      rd_caps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (wr_i.set) begin
        valid_q[wr_i.addr] <= 1'b1;
      end else if (wr_i.clr) begin
        valid_q[wr_i.addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ident_q <= ident_mem[rd_addr_i];
    rd_owner_q <= owner_mem[rd_addr_i];
    rd_caps_q  <= caps_mem[rd_addr_i];
    if (wr_i.set) begin
      ident_mem[wr_i.addr] <= wr_i.ident;
      owner_mem[wr_i.addr] <= wr_i.owner;
      caps_mem[wr_i.addr]  <= wr_i.caps;
    end
  end

  assign rd_o.valid = rd_valid_q;
  assign rd_o.ident = rd_ident_q;
  assign rd_o.owner = rd_owner_q;
  assign rd_o.caps  = rd_caps_q;

endmodule

// File: sv/ctt_ctrl.sv
`timescale 1ns / 1ps

module ctt_ctrl import ctt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [ID_W-1:0]     user_id_i,
  input  logic [ID_W-1:0]     token_key_i,
  input  logic [CAPS_W-1:0]   new_caps_i,
  input  user_rd_t            user_rd_i,
  input  token_rd_t           token_rd_i,
  output logic [USER_AW-1:0]  user_rd_addr_o,
  output user_wr_t            user_wr_o,
  output logic [TOKEN_AW-1:0] token_rd_addr_o,
  output token_wr_t           token_wr_o,
  output logic                busy_o,
  output logic                res_vld_o,
  output result_t             res_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [ID_W-1:0]     uid_q, uid_d;
  logic [ID_W-1:0]     key_q, key_d;
  logic [CAPS_W-1:0]   new_caps_q, new_caps_d;
  logic [CAPS_W-1:0]   ucaps_q, ucaps_d;
  logic                tgt_token_q, tgt_token_d;
  logic                free_q, free_d;
  logic [SCAN_W-1:0]   issue_q, issue_d;
  logic                pend_q, pend_d;
  logic [SCAN_W-1:0]   cidx_q, cidx_d;
  logic [ID_W-1:0]     next_q, next_d;
  logic [TCNT_W-1:0]   tcnt_q, tcnt_d;
  logic [UCNT_W-1:0]   ucnt_q, ucnt_d;

  logic [SCAN_W-1:0] limit;
  logic [SCAN_W-1:0] last_idx;
  logic              cur_valid;
  logic [ID_W-1:0]   cur_ident;
  logic [ID_W-1:0]   want_ident;
  logic              hit;
  logic              scan_end;

  always_comb begin
    limit      = tgt_token_q ? TOKEN_LIMIT : USER_LIMIT;
    last_idx   = tgt_token_q ? TOKEN_LAST : USER_LAST;
    cur_valid  = tgt_token_q ? token_rd_i.valid : user_rd_i.valid;
    cur_ident  = tgt_token_q ? token_rd_i.ident : user_rd_i.ident;
    want_ident = tgt_token_q ? key_q : uid_q;
    if (free_q) begin
      hit = pend_q && !cur_valid;
    end else begin
      hit = pend_q && cur_valid && (cur_ident == want_ident);
    end
    scan_end = hit || (pend_q && (cidx_q == last_idx));
  end

  assign user_rd_addr_o  = issue_q[USER_AW-1:0];
  assign token_rd_addr_o = issue_q[TOKEN_AW-1:0];
  assign busy_o          = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    uid_d       = uid_q;
    key_d       = key_q;
    new_caps_d  = new_caps_q;
    ucaps_d     = ucaps_q;
    tgt_token_d = tgt_token_q;
    free_d      = free_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    cidx_d      = cidx_q;
    next_d      = next_q;
    tcnt_d      = tcnt_q;
    ucnt_d      = ucnt_q;
    user_wr_o   = '0;
    token_wr_o  = '0;
    res_vld_o   = 1'b0;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mode_d     = mode_i;
          uid_d      = user_id_i;
          key_d      = token_key_i;
          new_caps_d = new_caps_i;
          free_d     = 1'b0;
          issue_d    = '0;
          pend_d     = 1'b0;
          unique case (mode_i) inside
            MODE_LOGIN, MODE_ADD: begin
              tgt_token_d = 1'b0;
              state_d     = S_SCAN;
            end
            MODE_VERIFY, MODE_REVOKE: begin
              tgt_token_d = 1'b1;
              state_d     = S_SCAN;
            end
            MODE_STATUS: begin
              res_vld_o         = 1'b1;
              res_o.status      = ST_OK;
              res_o.live_tokens = LIVE_TOKENS_W'(tcnt_q);
              res_o.live_users  = LIVE_USERS_W'(ucnt_q);
            end
            default: begin
              res_vld_o    = 1'b1;
              res_o.status = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_SCAN: begin
        pend_d = (issue_q < limit);
        cidx_d = issue_q;
        if (issue_q < limit) begin
          issue_d = issue_q + SCAN_W'(1);
        end
        if (scan_end) begin
          pend_d  = 1'b0;
          issue_d = '0;
          unique case (mode_q)
            MODE_LOGIN: begin
              if (!free_q) begin
                if (hit) begin
                  ucaps_d     = user_rd_i.caps;
                  tgt_token_d = 1'b1;
                  free_d      = 1'b1;
                end else begin
                  res_vld_o    = 1'b1;
                  res_o.status = ST_NOT_FOUND;
                end
              end else if (hit) begin
                token_wr_o.set   = 1'b1;
                token_wr_o.addr  = cidx_q[TOKEN_AW-1:0];
                token_wr_o.ident = next_q;
                token_wr_o.owner = uid_q;
                token_wr_o.caps  = ucaps_q;
                next_d           = next_q + ID_W'(1);
                tcnt_d           = tcnt_q + TCNT_W'(1);
                res_vld_o        = 1'b1;
                res_o.status     = ST_OK;
                res_o.issued     = next_q;
              end else begin
                res_vld_o    = 1'b1;
                res_o.status = ST_TOKENS_FULL;
              end
            end
            MODE_VERIFY: begin
              res_vld_o = 1'b1;
              if (hit) begin
                res_o.status = ST_OK;
                res_o.owner  = token_rd_i.owner;
                res_o.caps   = token_rd_i.caps;
              end else begin
                res_o.status = ST_NOT_FOUND;
              end
            end
            MODE_REVOKE: begin
              res_vld_o    = 1'b1;
              res_o.status = ST_OK;
              if (hit) begin
                token_wr_o.clr  = 1'b1;
                token_wr_o.addr = cidx_q[TOKEN_AW-1:0];
                tcnt_d          = tcnt_q - TCNT_W'(1);
              end
            end
            MODE_ADD: begin
              if (!free_q) begin
                if (hit) begin
                  res_vld_o    = 1'b1;
                  res_o.status = ST_USER_EXISTS;
                end else begin
                  free_d = 1'b1;
                end
              end else if (hit) begin
                user_wr_o.en    = 1'b1;
                user_wr_o.addr  = cidx_q[USER_AW-1:0];
                user_wr_o.ident = uid_q;
                user_wr_o.caps  = new_caps_q;
                ucnt_d          = ucnt_q + UCNT_W'(1);
                res_vld_o       = 1'b1;
                res_o.status    = ST_OK;
              end else begin
                res_vld_o    = 1'b1;
                res_o.status = ST_USERS_FULL;
              end
            end
            default: begin
              res_vld_o    = 1'b1;
              res_o.status = ST_NOT_FOUND;
            end
          endcase
          if (res_vld_o) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_LOGIN;
      tgt_token_q <= 1'b0;
      free_q      <= 1'b0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      cidx_q      <= '0;
      next_q      <= NEXT_IDENT_RST;
      tcnt_q      <= '0;
      ucnt_q      <= USER_COUNT_RST;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      tgt_token_q <= tgt_token_d;
      free_q      <= free_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      cidx_q      <= cidx_d;
      next_q      <= next_d;
      tcnt_q      <= tcnt_d;
      ucnt_q      <= ucnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    uid_q      <= uid_d;
    key_q      <= key_d;
    new_caps_q <= new_caps_d;
    ucaps_q    <= ucaps_d;
  end

endmodule

// File: sv/capability_token_table.sv
`timescale 1ns / 1ps

// Capability token table. A request is taken when start is high and busy is low;
// its single result is registered and appears in the cycle after the request
// completes, with done_o high for exactly one cycle, and the receiver cannot
// stall it. Each table is searched one entry per cycle through a synchronous
// memory read port: a login scans the user table and, if the user is found,
// the token table, verify and revoke scan the token table, add-user scans the
// user table for the id and then for a free slot, and status or an unused mode
// returns its result on the cycle after it is taken, with busy staying low. A
// new request may be taken in the cycle in which the previous result is shown.
// No clearing pass is needed after reset.
module capability_token_table import ctt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [ID_W-1:0]          user_id_i,
  input  logic [ID_W-1:0]          token_key_i,
  input  logic [CAPS_W-1:0]        new_caps_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_code_o,
  output logic [ID_W-1:0]          issued_token_o,
  output logic [ID_W-1:0]          owner_id_o,
  output logic [CAPS_W-1:0]        owner_caps_o,
  output logic [LIVE_TOKENS_W-1:0] live_tokens_o,
  output logic [LIVE_USERS_W-1:0]  live_users_o
);

  logic [USER_AW-1:0]  user_rd_addr;
  logic [TOKEN_AW-1:0] token_rd_addr;
  user_wr_t            user_wr;
  user_rd_t            user_rd;
  token_wr_t           token_wr;
  token_rd_t           token_rd;
  logic                res_vld;
  result_t             res;
  logic                done_q;
  result_t             res_q;

  ctt_user_store u_user_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (user_rd_addr),
    .wr_i      (user_wr),
    .rd_o      (user_rd)
  );

  ctt_token_store u_token_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (token_rd_addr),
    .wr_i      (token_wr),
    .rd_o      (token_rd)
  );

  ctt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .mode_i          (mode_i),
    .user_id_i       (user_id_i),
    .token_key_i     (token_key_i),
    .new_caps_i      (new_caps_i),
    .user_rd_i       (user_rd),
    .token_rd_i      (token_rd),
    .user_rd_addr_o  (user_rd_addr),
    .user_wr_o       (user_wr),
    .token_rd_addr_o (token_rd_addr),
    .token_wr_o      (token_wr),
    .busy_o          (busy),
    .res_vld_o       (res_vld),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      res_q <= res;
    end
  end

  assign done_o         = done_q;
  assign status_code_o  = res_q.status;
  assign issued_token_o = res_q.issued;
  assign owner_id_o     = res_q.owner;
  assign owner_caps_o   = res_q.caps;
  assign live_tokens_o  = res_q.live_tokens;
  assign live_users_o   = res_q.live_users;

endmodule

// File: sv/ctt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctt_checker import ctt_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic [MODE_W-1:0]        mode_i,
  input logic [ID_W-1:0]          user_id_i,
  input logic [ID_W-1:0]          token_key_i,
  input logic [CAPS_W-1:0]        new_caps_i,
  input logic                     done_o,
  input logic [STATUS_W-1:0]      status_code_o,
  input logic [ID_W-1:0]          issued_token_o,
  input logic [ID_W-1:0]          owner_id_o,
  input logic [CAPS_W-1:0]        owner_caps_o,
  input logic [LIVE_TOKENS_W-1:0] live_tokens_o,
  input logic [LIVE_USERS_W-1:0]  live_users_o
);

  logic accept;
  logic quick_mode;
  logic idle_no_req;
  logic quick_req;
  logic scan_req;
  logic fail_shown;
  logic data_clear;
  logic counts_ok;

  assign accept      = start && !busy;
  assign quick_mode  = (mode_i > MODE_ADD);
  assign idle_no_req = !busy && !accept;
  assign quick_req   = accept && quick_mode;
  assign scan_req    = accept && !quick_mode;
  assign fail_shown  = done_o && (status_code_o != ST_OK);
  assign data_clear  = (issued_token_o == '0) && (owner_id_o == '0) && (owner_caps_o == '0);
  assign counts_ok   = (live_tokens_o <= LIVE_TOKENS_W'(TOKEN_SLOTS)) &&
                       (live_users_o <= LIVE_USERS_W'(USER_SLOTS));

  `ASSERT_NEXT(a_done_has_request, clk_i, rst_ni, idle_no_req, !done_o, "result without request")
  `ASSERT_NEXT(a_quick_result, clk_i, rst_ni, quick_req, done_o && !busy, "quick result missing")
  `ASSERT_NEXT(a_scan_busy, clk_i, rst_ni, scan_req, busy && !done_o, "scan not held busy")
  `ASSERT_IMPLIES(a_fail_clean, clk_i, rst_ni, fail_shown, data_clear, "failed request has data")
  `ASSERT_IMPLIES(a_counts_bound, clk_i, rst_ni, done_o, counts_ok, "live count out of range")

endmodule

bind capability_token_table ctt_checker u_ctt_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ctt_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned RANDOM_REQS = 1200;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   uid;
    logic [ID_W-1:0]   key;
    logic [CAPS_W-1:0] caps;
    int unsigned       gap;
    bit                drain;
  } request_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [MODE_W-1:0]        mode_i = MODE_STATUS;
  logic [ID_W-1:0]          user_id_i = '0;
  logic [ID_W-1:0]          token_key_i = '0;
  logic [CAPS_W-1:0]        new_caps_i = '0;
  logic                     done_o;
  logic [STATUS_W-1:0]      status_code_o;
  logic [ID_W-1:0]          issued_token_o;
  logic [ID_W-1:0]          owner_id_o;
  logic [CAPS_W-1:0]        owner_caps_o;
  logic [LIVE_TOKENS_W-1:0] live_tokens_o;
  logic [LIVE_USERS_W-1:0]  live_users_o;

  capability_token_table DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .user_id_i      (user_id_i),
    .token_key_i    (token_key_i),
    .new_caps_i     (new_caps_i),
    .done_o         (done_o),
    .status_code_o  (status_code_o),
    .issued_token_o (issued_token_o),
    .owner_id_o     (owner_id_o),
    .owner_caps_o   (owner_caps_o),
    .live_tokens_o  (live_tokens_o),
    .live_users_o   (live_users_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the user and token tables.
  bit                usr_live [USER_SLOTS];
  logic [ID_W-1:0]   usr_id   [USER_SLOTS];
  logic [CAPS_W-1:0] usr_caps [USER_SLOTS];
  bit                tok_live [TOKEN_SLOTS];
  logic [ID_W-1:0]   tok_id   [TOKEN_SLOTS];
  logic [ID_W-1:0]   tok_owner[TOKEN_SLOTS];
  logic [CAPS_W-1:0] tok_caps [TOKEN_SLOTS];
  logic [ID_W-1:0]   id_counter;
  int unsigned       tok_total;
  int unsigned       usr_total;

  request_t    request_q[$];
  result_t     due_results[$];
  request_t    shown;
  request_t    staged;
  bit          staged_valid = 1'b0;
  int unsigned wait_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned mode_hits[8];
  int unsigned status_hits[8];

  logic [ID_W-1:0] known_ids[$];
  int unsigned     gen_logins = 0;

  function automatic int user_slot_of(logic [ID_W-1:0] id);
    for (int i = 0; i < USER_SLOTS; i++) begin
      if (usr_live[i] && usr_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int token_slot_of(logic [ID_W-1:0] id);
    for (int i = 0; i < TOKEN_SLOTS; i++) begin
      if (tok_live[i] && tok_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic result_t apply_request(request_t r);
    result_t res;
    int u;
    int t;
    res = '0;
    res.status = ST_OK;
    u = -1;
    t = -1;
    case (r.mode)
      MODE_LOGIN: begin
        u = user_slot_of(r.uid);
        for (int i = 0; i < TOKEN_SLOTS && t < 0; i++) begin
          if (!tok_live[i]) t = i;
        end
        if (u < 0) begin
          res.status = ST_NOT_FOUND;
        end else if (t < 0) begin
          res.status = ST_TOKENS_FULL;
        end else begin
          res.issued = id_counter;
          tok_id[t] = id_counter;
          tok_owner[t] = r.uid;
          tok_caps[t] = usr_caps[u];
          tok_live[t] = 1'b1;
          id_counter = id_counter + 1'b1;
          tok_total++;
        end
      end
      MODE_VERIFY: begin
        t = token_slot_of(r.key);
        if (t < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.owner = tok_owner[t];
          res.caps = tok_caps[t];
        end
      end
      MODE_REVOKE: begin
        t = token_slot_of(r.key);
        if (t >= 0) begin
          tok_live[t] = 1'b0;
          tok_total--;
        end
      end
      MODE_ADD: begin
        for (int i = 0; i < USER_SLOTS && u < 0; i++) begin
          if (!usr_live[i]) u = i;
        end
        if (user_slot_of(r.uid) >= 0) begin
          res.status = ST_USER_EXISTS;
        end else if (u < 0) begin
          res.status = ST_USERS_FULL;
        end else begin
          usr_id[u] = r.uid;
          usr_caps[u] = r.caps;
          usr_live[u] = 1'b1;
          usr_total++;
        end
      end
      MODE_STATUS: begin
        res.live_tokens = LIVE_TOKENS_W'(tok_total);
        res.live_users = LIVE_USERS_W'(usr_total);
      end
      default: begin
        res.status = ST_NOT_FOUND;
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      n_errors++;
    end
  endfunction

  // Generator side: a rough view of which users exist and which ids were issued.
  function automatic void push_req(logic [MODE_W-1:0] mode, logic [ID_W-1:0] uid,
                                   logic [ID_W-1:0] key, logic [CAPS_W-1:0] caps,
                                   int unsigned gap, bit drain);
    request_t r;
    bit seen;
    r.mode = mode;
    r.uid = uid;
    r.key = key;
    r.caps = caps;
    r.gap = gap;
    r.drain = drain;
    request_q.push_back(r);
    seen = 1'b0;
    if (mode == MODE_LOGIN) gen_logins++;
    if (mode == MODE_ADD) begin
      foreach (known_ids[i]) if (known_ids[i] == uid) seen = 1'b1;
      if (!seen && known_ids.size() < USER_SLOTS) known_ids.push_back(uid);
    end
  endfunction

  function automatic logic [ID_W-1:0] pick_user();
    if ($urandom_range(0, 99) < 80) return known_ids[$urandom_range(0, known_ids.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [ID_W-1:0] pick_key();
    int unsigned lo;
    lo = (gen_logins > 80) ? gen_logins - 80 : 1;
    if ($urandom_range(0, 99) < 80) return $urandom_range(lo, gen_logins + 1);
    return $urandom;
  endfunction

  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (start && !busy) begin
        due_results.push_back(apply_request(shown));
        mode_hits[shown.mode]++;
      end
      if (!start || !busy) begin
        if (!staged_valid && request_q.size() != 0) begin
          staged = request_q.pop_front();
          staged_valid = 1'b1;
          wait_left = staged.gap;
        end
        if (staged_valid && wait_left == 0 &&
            (!staged.drain || (due_results.size() == 0 && !done_o))) begin
          shown = staged;
          staged_valid = 1'b0;
          start <= 1'b1;
          mode_i <= staged.mode;
          user_id_i <= staged.uid;
          token_key_i <= staged.key;
          new_caps_i <= staged.caps;
        end else begin
          start <= 1'b0;
          if (staged_valid && wait_left != 0) wait_left--;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni && done_o === 1'b1) begin
      status_hits[status_code_o]++;
      if (due_results.size() == 0) begin
        $error("result with status %0d arrived with no request outstanding", status_code_o);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        check_field("status_code", 32'(want.status), 32'(status_code_o));
        check_field("issued_token", want.issued, issued_token_o);
        check_field("owner_id", want.owner, owner_id_o);
        check_field("owner_caps", want.caps, owner_caps_o);
        check_field("live_tokens", 32'(want.live_tokens), 32'(live_tokens_o));
        check_field("live_users", 32'(want.live_users), 32'(live_users_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned roll;
    int unsigned round;
    bit gaps_on;
    bit timed_out;
    logic [MODE_W-1:0] m;

    foreach (usr_live[i]) begin
      usr_live[i] = 1'b0;
      usr_id[i] = '0;
      usr_caps[i] = '0;
    end
    foreach (tok_live[i]) begin
      tok_live[i] = 1'b0;
      tok_id[i] = '0;
      tok_owner[i] = '0;
      tok_caps[i] = '0;
    end
    usr_live[0] = 1'b1;
    usr_id[0] = ROOT_IDENT;
    usr_caps[0] = ROOT_CAPS;
    usr_live[1] = 1'b1;
    usr_id[1] = ADMIN_IDENT;
    usr_caps[1] = ADMIN_CAPS;
    id_counter = NEXT_IDENT_RST;
    tok_total = 0;
    usr_total = 2;
    known_ids.push_back(ROOT_IDENT);
    known_ids.push_back(ADMIN_IDENT);

    push_req(MODE_STATUS, '0, '0, '0, 0, 1'b0);
    push_req(MODE_LOGIN, ROOT_IDENT, '1, '1, 0, 1'b0);
    push_req(MODE_LOGIN, ADMIN_IDENT, '0, '0, 0, 1'b0);
    push_req(MODE_LOGIN, 32'hFFFF_FFFF, '0, '0, 1, 1'b0);
    push_req(MODE_VERIFY, '1, 32'd1, '1, 0, 1'b0);
    push_req(MODE_VERIFY, '0, 32'd0, '0, 2, 1'b0);
    push_req(MODE_VERIFY, '0, 32'hFFFF_FFFF, '0, 0, 1'b0);
    push_req(MODE_REVOKE, '0, 32'd2, '0, 0, 1'b0);
    push_req(MODE_REVOKE, '0, 32'd2, '0, 3, 1'b0);
    push_req(MODE_VERIFY, '0, 32'd2, '0, 0, 1'b0);
    push_req(MODE_ADD, ROOT_IDENT, '0, 32'h1234_5678, 0, 1'b0);
    push_req(MODE_ADD, ADMIN_IDENT, '0, '1, 0, 1'b0);
    push_req(MODE_ADD, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 0, 1'b0);
    push_req(MODE_ADD, 32'h8000_0000, '0, 32'h0000_0000, 7, 1'b0);
    push_req(MODE_LOGIN, 32'hFFFF_FFFF, '0, '0, 0, 1'b0);
    push_req(MODE_VERIFY, '0, 32'd3, '0, 0, 1'b0);
    push_req(MODE_LOGIN, 32'h8000_0000, '0, '0, 0, 1'b0);
    push_req(MODE_VERIFY, '0, 32'd4, '0, 0, 1'b0);
    for (int v = MODE_STATUS + 1; v < 8; v++) begin
      push_req(MODE_W'(v), $urandom, $urandom, $urandom, 0, 1'b0);
    end
    push_req(MODE_STATUS, '1, '1, '1, 0, 1'b1);

    // Random rounds: mixed traffic, login bursts that fill the token table,
    // revoke sweeps that drain it, and bursts of new users.
    round = 0;
    while (request_q.size() < RANDOM_REQS + 22) begin
      kind = $urandom_range(0, 5);
      gaps_on = ($urandom_range(0, 2) != 0);
      len = (kind == 1) ? 70 : (kind == 2) ? 50 : (kind == 3) ? 8 : 40;
      for (int n = 0; n < len; n++) begin
        roll = $urandom_range(0, 99);
        if (kind == 1) m = (roll < 90) ? MODE_LOGIN : MODE_STATUS;
        else if (kind == 2) m = (roll < 60) ? MODE_REVOKE : (roll < 90) ? MODE_VERIFY : MODE_STATUS;
        else if (kind == 3) m = (roll < 85) ? MODE_ADD : MODE_LOGIN;
        else if (roll < 35) m = MODE_LOGIN;
        else if (roll < 60) m = MODE_VERIFY;
        else if (roll < 83) m = MODE_REVOKE;
        else if (roll < 89) m = MODE_ADD;
        else if (roll < 97) m = MODE_STATUS;
        else m = MODE_W'($urandom_range(MODE_STATUS + 1, 7));
        push_req(m, (m == MODE_ADD && roll % 3 == 0) ? $urandom : pick_user(), pick_key(),
                 $urandom, gaps_on ? $urandom_range(0, 7) : 0,
                 n == 0 && (round == 0 || $urandom_range(0, 1) == 1));
      end
      round++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while ((request_q.size() != 0 || staged_valid || start || due_results.size() != 0) &&
           idle_cycles < IDLE_LIMIT) begin
      @(negedge clk_i);
    end
    timed_out = (idle_cycles >= IDLE_LIMIT);

    if (timed_out) begin
      $display("testbench: done, errors");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk_i);
      $display("Requests: %0d login, %0d verify, %0d revoke, %0d add-user, %0d status, %0d unused.",
               mode_hits[MODE_LOGIN], mode_hits[MODE_VERIFY], mode_hits[MODE_REVOKE],
               mode_hits[MODE_ADD], mode_hits[MODE_STATUS],
               mode_hits[5] + mode_hits[6] + mode_hits[7]);
      $display("Outcomes: %0d ok, %0d not found, %0d tokens full, %0d user exists, %0d users full.",
               status_hits[ST_OK], status_hits[ST_NOT_FOUND], status_hits[ST_TOKENS_FULL],
               status_hits[ST_USER_EXISTS], status_hits[ST_USERS_FULL]);
      if (n_errors == 0) begin
        $display("testbench: done, clean");
      end else begin
        $display("testbench: done, errors");
      end
    end
    $finish;
  end

endmodule
